// ===== hw/rtl/touch_sample_filter_sequencer_assert.svh =====
// Assertion macros shared by the touch filter RTL.
`ifndef TOUCH_SAMPLE_FILTER_SEQUENCER_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_SEQUENCER_ASSERT_SVH

// Checked on every edge, reset included.
`define TSFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked outside reset only.
`define TSFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== hw/rtl/tsfs_pkg.sv =====
package tsfs_pkg;

  localparam int SampleW       = 10;
  localparam int WindowLen     = 4;
  localparam int CmdQueueDepth = 2;

  typedef logic [SampleW-1:0] sample_t;

  localparam sample_t LIMIT_RESET = sample_t'(10);

  // Panel controller modes.
  localparam logic [1:0] MODE_WAIT_DOWN = 2'd0;
  localparam logic [1:0] MODE_WAIT_UP   = 2'd1;
  localparam logic [1:0] MODE_MEASURE   = 2'd2;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_RELEASE,
    OP_MEASURE,
    OP_WINDOW
  } op_e;

  typedef struct packed {
    op_e                           op;
    sample_t [WindowLen-1:0]       x;
    sample_t [WindowLen-1:0]       y;
  } cmd_t;

  typedef struct packed {
    logic       report_valid;
    logic       touching;
    sample_t    x_position;
    sample_t    y_position;
    logic [1:0] panel_mode;
    logic       start_conversion;
    logic       arm_timer;
  } res_t;

endpackage

// ===== hw/rtl/tsfs_front.sv =====
`include "touch_sample_filter_sequencer_assert.svh"

module tsfs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              func_i,
  input  logic              pen_lifted_i,
  input  tsfs_pkg::sample_t x_sample_i,
  input  tsfs_pkg::sample_t y_sample_i,
  output tsfs_pkg::cmd_t    cmd_o
);

  logic [1:0]        sample_count_q, sample_count_d;
  tsfs_pkg::sample_t x_q [3];
  tsfs_pkg::sample_t y_q [3];
  logic              store;

  always_comb begin
    sample_count_d = sample_count_q;
    store          = 1'b0;
    cmd_o.op       = tsfs_pkg::OP_MEASURE;
    cmd_o.x        = {x_sample_i, x_q[2], x_q[1], x_q[0]};
    cmd_o.y        = {y_sample_i, y_q[2], y_q[1], y_q[0]};
    if (pen_lifted_i) begin
      cmd_o.op = tsfs_pkg::OP_RELEASE;
      if (!func_i) begin
        sample_count_d = 2'd0;
      end
    end else if (!func_i) begin
      if (sample_count_q == 2'd3) begin
        cmd_o.op       = tsfs_pkg::OP_WINDOW;
        sample_count_d = 2'd0;
      end else begin
        store          = 1'b1;
        sample_count_d = sample_count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 2'd0;
    end else if (take_i) begin
      sample_count_q <= sample_count_d;
    end
  end

  // window entries: no reset, written before any read
  always_ff @(posedge clk_i) begin
    if (take_i && store) begin
      x_q[sample_count_q] <= x_sample_i;
      y_q[sample_count_q] <= y_sample_i;
    end
  end

  `TSFS_ASSERT(a_count_wraps,
    (take_i && !pen_lifted_i && !func_i && sample_count_q == 2'd3) |=> sample_count_q == 2'd0,
    "sample count did not clear after fourth pair")
  `TSFS_ASSERT(a_window_cmd_only_at_three,
    (take_i && cmd_o.op == tsfs_pkg::OP_WINDOW) |-> sample_count_q == 2'd3,
    "window command issued before four pairs")

endmodule

// ===== hw/rtl/tsfs_cmd_queue.sv =====
`include "touch_sample_filter_sequencer_assert.svh"

module tsfs_cmd_queue #(
  parameter int Depth = tsfs_pkg::CmdQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsfs_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tsfs_pkg::cmd_t cmd_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tsfs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `TSFS_ASSERT(a_count_bounded, count_q <= CntW'(Depth),
    "command queue count beyond depth")
  `TSFS_ASSERT(a_ptrs_meet_when_empty, empty_o |-> wr_ptr_q == rd_ptr_q,
    "queue pointers differ while empty")

endmodule

// ===== hw/rtl/tsfs_back.sv =====
`include "touch_sample_filter_sequencer_assert.svh"

module tsfs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  tsfs_pkg::sample_t cfg_wdata_i,
  input  logic              cmd_avail_i,
  input  tsfs_pkg::cmd_t    cmd_i,
  output logic              cmd_take_o,
  input  logic              res_pop_i,
  output logic              res_valid_o,
  output tsfs_pkg::res_t    res_o
);

  tsfs_pkg::sample_t limit_q;
  logic              out_valid_q;
  tsfs_pkg::res_t    res_q, res_d;
  logic              steady;
  logic [11:0]       sum_x, sum_y;

  // checks sample 2 against mean(0,1) and sample 3 against mean(1,2)
  function automatic logic window_steady(
    input tsfs_pkg::sample_t [3:0] w,
    input tsfs_pkg::sample_t       lim
  );
    logic [10:0]       s1, s2;
    tsfs_pkg::sample_t m1, m2, d1, d2;
    s1 = {1'b0, w[0]} + {1'b0, w[1]};
    s2 = {1'b0, w[1]} + {1'b0, w[2]};
    m1 = s1[10:1];
    m2 = s2[10:1];
    d1 = (w[2] > m1) ? w[2] - m1 : m1 - w[2];
    d2 = (w[3] > m2) ? w[3] - m2 : m2 - w[3];
    return (d1 <= lim) && (d2 <= lim);
  endfunction

  assign cmd_take_o  = cmd_avail_i && (!out_valid_q || res_pop_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    steady = window_steady(cmd_i.x, limit_q) && window_steady(cmd_i.y, limit_q);
    sum_x  = 12'(cmd_i.x[0]) + 12'(cmd_i.x[1]) + 12'(cmd_i.x[2]) + 12'(cmd_i.x[3]);
    sum_y  = 12'(cmd_i.y[0]) + 12'(cmd_i.y[1]) + 12'(cmd_i.y[2]) + 12'(cmd_i.y[3]);
    res_d  = '0;
    unique case (cmd_i.op)
      tsfs_pkg::OP_RELEASE: begin
        res_d.report_valid = 1'b1;
        res_d.panel_mode   = tsfs_pkg::MODE_WAIT_DOWN;
      end
      tsfs_pkg::OP_WINDOW: begin
        res_d.panel_mode = tsfs_pkg::MODE_WAIT_UP;
        res_d.arm_timer  = 1'b1;
        if (steady) begin
          res_d.report_valid = 1'b1;
          res_d.touching     = 1'b1;
          res_d.x_position   = sum_x[11:2];
          res_d.y_position   = sum_y[11:2];
        end
      end
      default: begin
        res_d.panel_mode       = tsfs_pkg::MODE_MEASURE;
        res_d.start_conversion = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= tsfs_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_take_o) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      res_q <= res_d;
    end
  end

  `TSFS_ASSERT(a_take_fills_output, cmd_take_o |=> out_valid_q,
    "output register empty after command taken")
  `TSFS_ASSERT(a_touch_means_wait_up,
    (out_valid_q && res_q.touching) |->
      (res_q.report_valid && res_q.panel_mode == tsfs_pkg::MODE_WAIT_UP),
    "touch report without pen-up rearm")

endmodule

// ===== hw/rtl/touch_sample_filter_sequencer.sv =====
// Channel   Ports                                          Beat when
// -------   ---------------------------------------------  ------------------
// input     push, full, func_i, pen_lifted_i, x/y_sample_i push && !full
// result    pop, empty, report_valid_o .. arm_timer_o      pop && !empty
// config    cfg_we_i, cfg_wdata_i (deviation limit)        cfg_we_i
//
// One input beat per cycle sustained while full stays low; each beat gives one result beat.
// An accepted beat goes into the command queue and from there into the
// output register, which drives the result ports.
// full rises when the command queue holds QueueDepth commands, i.e. when
// results back up; the output register refills in the cycle it is popped.
// Reset clears the sample count, queue pointers and output valid; the
// limit returns to 10. Sample window registers are not reset.
`include "touch_sample_filter_sequencer_assert.svh"

module touch_sample_filter_sequencer #(
  parameter int QueueDepth = tsfs_pkg::CmdQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input beats
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic              pen_lifted_i,
  input  tsfs_pkg::sample_t x_sample_i,
  input  tsfs_pkg::sample_t y_sample_i,
  // result beats
  input  logic              pop,
  output logic              empty,
  output logic              report_valid_o,
  output logic              touching_o,
  output tsfs_pkg::sample_t x_position_o,
  output tsfs_pkg::sample_t y_position_o,
  output logic [1:0]        panel_mode_o,
  output logic              start_conversion_o,
  output logic              arm_timer_o,
  // configuration
  input  logic              cfg_we_i,
  input  tsfs_pkg::sample_t cfg_wdata_i
);

  tsfs_pkg::cmd_t front_cmd, queue_cmd;
  tsfs_pkg::res_t res;
  logic           take, q_empty, cmd_take, res_valid;

  assign take = push && !full;

  // Front: sample count and window, classifies each beat into a command.
  tsfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .func_i       (func_i),
    .pen_lifted_i (pen_lifted_i),
    .x_sample_i   (x_sample_i),
    .y_sample_i   (y_sample_i),
    .cmd_o        (front_cmd)
  );

  // Short queue decouples classification from result generation.
  tsfs_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_take),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  // Back: outlier checks, averaging, output register.
  tsfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_avail_i (!q_empty),
    .cmd_i       (queue_cmd),
    .cmd_take_o  (cmd_take),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty              = !res_valid;
  assign report_valid_o     = res.report_valid;
  assign touching_o         = res.touching;
  assign x_position_o       = res.x_position;
  assign y_position_o       = res.y_position;
  assign panel_mode_o       = res.panel_mode;
  assign start_conversion_o = res.start_conversion;
  assign arm_timer_o        = res.arm_timer;

  `TSFS_ASSERT(a_no_take_when_idle, q_empty |-> !cmd_take,
    "back took a command from an empty queue")
  `TSFS_ASSERT(a_beat_reaches_back, (take && q_empty && empty) |=> !q_empty,
    "accepted beat missing from command queue")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tsfs_pkg::*;

  // Event kinds carried on func_i.
  localparam logic FUNC_CONVERSION = 1'b0;
  localparam logic FUNC_EVENT      = 1'b1;

  // Watchdog: far beyond the slowest legal run (about 1.8k beats, each with
  // random gaps plus receiver stalls).
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Filter predictor plus the queue of reports still owed by the block.
  class report_checker;
    sample_t              limit;
    logic [1:0]           pairs_held;
    sample_t              x_win[WindowLen];
    sample_t              y_win[WindowLen];
    res_t                 reports_due[$];
    int unsigned          fails;

    function new();
      limit      = LIMIT_RESET;
      pairs_held = '0;
      fails      = 0;
      foreach (x_win[k]) begin
        x_win[k] = '0;
        y_win[k] = '0;
      end
    endfunction

    function int distance(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Each of the last two samples must sit within the limit of the floor
    // mean of the two samples before it.
    function bit steady(sample_t w[WindowLen]);
      int m1, m2;
      m1 = (int'(w[0]) + int'(w[1])) >> 1;
      m2 = (int'(w[1]) + int'(w[2])) >> 1;
      if (distance(int'(w[2]), m1) > int'(limit)) return 1'b0;
      if (distance(int'(w[3]), m2) > int'(limit)) return 1'b0;
      return 1'b1;
    endfunction

    function sample_t average(sample_t w[WindowLen]);
      int total;
      total = int'(w[0]) + int'(w[1]) + int'(w[2]) + int'(w[3]);
      return sample_t'(total >> 2);
    endfunction

    // Accepted input beat: advance the state and queue the report it owes.
    function void note_input(logic func, logic lifted, sample_t xs, sample_t ys);
      res_t r;
      r = '0;
      if (lifted) begin
        // Release; only a conversion clears the pair count.
        if (func == FUNC_CONVERSION) pairs_held = '0;
        r.report_valid = 1'b1;
        r.panel_mode   = MODE_WAIT_DOWN;
      end else if (func == FUNC_EVENT) begin
        r.panel_mode       = MODE_MEASURE;
        r.start_conversion = 1'b1;
      end else begin
        x_win[pairs_held] = xs;
        y_win[pairs_held] = ys;
        if (pairs_held != 2'(WindowLen - 1)) begin
          pairs_held         = pairs_held + 2'd1;
          r.panel_mode       = MODE_MEASURE;
          r.start_conversion = 1'b1;
        end else begin
          // Window complete: report only if both axes are steady.
          pairs_held  = '0;
          r.panel_mode = MODE_WAIT_UP;
          r.arm_timer  = 1'b1;
          if (steady(x_win) && steady(y_win)) begin
            r.report_valid = 1'b1;
            r.touching     = 1'b1;
            r.x_position   = average(x_win);
            r.y_position   = average(y_win);
          end
        end
      end
      reports_due.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        fails++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (reports_due.size() == 0) begin
        $error("result beat with no report pending");
        fails++;
        return;
      end
      want = reports_due.pop_front();
      compare("report_valid", want.report_valid, got.report_valid);
      compare("touching", want.touching, got.touching);
      compare("x_position", want.x_position, got.x_position);
      compare("y_position", want.y_position, got.y_position);
      compare("panel_mode", want.panel_mode, got.panel_mode);
      compare("start_conversion", want.start_conversion, got.start_conversion);
      compare("arm_timer", want.arm_timer, got.arm_timer);
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push = 1'b0;
  logic    full;
  logic    func_i = 1'b0;
  logic    pen_lifted_i = 1'b0;
  sample_t x_sample_i = '0;
  sample_t y_sample_i = '0;
  logic    pop = 1'b0;
  logic    empty;
  logic    report_valid_o;
  logic    touching_o;
  sample_t x_position_o;
  sample_t y_position_o;
  logic [1:0] panel_mode_o;
  logic    start_conversion_o;
  logic    arm_timer_o;
  logic    cfg_we_i = 1'b0;
  sample_t cfg_wdata_i = '0;

  report_checker checker_h = new();
  int unsigned   beats_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycles = 0;
  int            cur_limit = int'(LIMIT_RESET);

  touch_sample_filter_sequencer u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .func_i             (func_i),
    .pen_lifted_i       (pen_lifted_i),
    .x_sample_i         (x_sample_i),
    .y_sample_i         (y_sample_i),
    .pop                (pop),
    .empty              (empty),
    .report_valid_o     (report_valid_o),
    .touching_o         (touching_o),
    .x_position_o       (x_position_o),
    .y_position_o       (y_position_o),
    .panel_mode_o       (panel_mode_o),
    .start_conversion_o (start_conversion_o),
    .arm_timer_o        (arm_timer_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall pattern switches between free-running, coin-flip,
  // sparse pops and long holds, each for a random stretch.
  int unsigned pop_mode = 0;
  int unsigned pop_stretch = 0;
  always @(negedge clk) begin
    if (pop_stretch == 0) begin
      pop_mode    = $urandom_range(0, 3);
      pop_stretch = $urandom_range(20, 200);
    end
    pop_stretch--;
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      2: pop <= ($urandom_range(0, 5) == 0);
      default: pop <= ((pop_stretch % 32) >= 28);
    endcase
  end

  // Result beats are taken at the rising edge.
  always @(posedge clk) begin
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.report_valid     = report_valid_o;
      got.touching         = touching_o;
      got.x_position       = x_position_o;
      got.y_position       = y_position_o;
      got.panel_mode       = panel_mode_o;
      got.start_conversion = start_conversion_o;
      got.arm_timer        = arm_timer_o;
      checker_h.check_report(got);
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // One input beat. Bursts of random length with random gaps; push stays
  // high across back-to-back beats inside a burst.
  task automatic send(logic func, logic lifted, sample_t xs, sample_t ys);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push         <= 1'b1;
    func_i       <= func;
    pen_lifted_i <= lifted;
    x_sample_i   <= xs;
    y_sample_i   <= ys;
    do @(posedge clk); while (full);
    checker_h.note_input(func, lifted, xs, ys);
    beats_sent++;
  endtask

  // Hold the sender until every owed report has been popped, then let the
  // pipeline settle.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(sample_t value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    checker_h.limit = value;
    cur_limit = int'(value);
  endtask

  function automatic int clip(int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  // Offset of a sample from its predecessors' mean; leans on the limit edge.
  function automatic int pick_offset(int lim);
    case ($urandom_range(0, 9))
      0: return lim + 1;
      1: return -(lim + 1);
      2: return lim;
      3: return -lim;
      4: return int'($urandom_range(0, 600)) - 300;
      default: return int'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  function automatic void make_axis(input int lim, output sample_t w[WindowLen]);
    int base, span, v0, v1, v2, v3;
    case ($urandom_range(0, 9))
      0: base = 0;
      1: base = 1023;
      default: base = $urandom_range(0, 1023);
    endcase
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
    v0 = clip(base + int'($urandom_range(0, 2 * span)) - span);
    v1 = clip(base + int'($urandom_range(0, 2 * span)) - span);
    v2 = clip(((v0 + v1) >> 1) + pick_offset(lim));
    v3 = clip(((v1 + v2) >> 1) + pick_offset(lim));
    w[0] = sample_t'(v0);
    w[1] = sample_t'(v1);
    w[2] = sample_t'(v2);
    w[3] = sample_t'(v3);
  endfunction

  // A touch as the panel sees it: optional pen-up conversion and pen-down, four
  // conversions with the odd timer tick between them, then maybe a trailing event.
  task automatic touch_sequence();
    sample_t xw[WindowLen];
    sample_t yw[WindowLen];
    // Pen-up conversion realigns the window after noise.
    if ($urandom_range(0, 2) == 0)
      send(FUNC_CONVERSION, 1'b1, sample_t'($urandom), sample_t'($urandom));
    if ($urandom_range(0, 1) == 1)
      send(FUNC_EVENT, 1'b0, sample_t'($urandom), sample_t'($urandom));
    make_axis(cur_limit, xw);
    make_axis(cur_limit, yw);
    for (int k = 0; k < WindowLen; k++) begin
      if ($urandom_range(0, 9) == 0)
        send(FUNC_EVENT, 1'b0, sample_t'($urandom), sample_t'($urandom));
      send(FUNC_CONVERSION, 1'b0, xw[k], yw[k]);
    end
    if ($urandom_range(0, 3) == 0)
      send(FUNC_EVENT, logic'($urandom_range(0, 1)), sample_t'($urandom),
           sample_t'($urandom));
  endtask

  // Interrupted touch: a few pairs, then the pen lifts by conversion or by
  // interrupt (the latter keeps the partial count).
  task automatic broken_touch();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) send(FUNC_CONVERSION, 1'b0, sample_t'($urandom), sample_t'($urandom));
    send(logic'($urandom_range(0, 1)), 1'b1, sample_t'($urandom), sample_t'($urandom));
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned target, pick;
    target = beats_sent + n;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) touch_sequence();
      else if (pick < 85) broken_touch();
      else send(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                sample_t'($urandom), sample_t'($urandom));
    end
  endtask

  task automatic send_window(sample_t x0, sample_t x1, sample_t x2, sample_t x3,
                             sample_t y0, sample_t y1, sample_t y2, sample_t y3);
    send(FUNC_CONVERSION, 1'b0, x0, y0);
    send(FUNC_CONVERSION, 1'b0, x1, y1);
    send(FUNC_CONVERSION, 1'b0, x2, y2);
    send(FUNC_CONVERSION, 1'b0, x3, y3);
  endtask

  // Directed beats at the reset limit of 10.
  task automatic directed();
    send(FUNC_CONVERSION, 1'b1, 10'h3ff, 10'h3ff);   // release by conversion
    send(FUNC_EVENT, 1'b0, 10'h3ff, 10'h000);        // pen down: measure
    send(FUNC_EVENT, 1'b1, 10'h000, 10'h3ff);        // release by interrupt
    send_window(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff,
                10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff); // full-scale touch
    send_window(10'h000, 10'h000, 10'h000, 10'h000,
                10'h000, 10'h000, 10'h000, 10'h000); // zero touch
    // Partial window; interrupt release keeps the count, conversion clears it.
    send(FUNC_CONVERSION, 1'b0, 10'd3, 10'd5);
    send(FUNC_CONVERSION, 1'b0, 10'd5, 10'd3);
    send(FUNC_EVENT, 1'b1, 10'd0, 10'd0);
    send(FUNC_EVENT, 1'b0, 10'd0, 10'd0);
    send(FUNC_CONVERSION, 1'b1, 10'd0, 10'd0);
    // First check fails on X.
    send_window(10'd100, 10'd100, 10'd111, 10'd100,
                10'd500, 10'd500, 10'd500, 10'd500);
    // Both checks pass: both checks on Y and the first on X sit exactly at the limit.
    send_window(10'd100, 10'd100, 10'd110, 10'd105,
                10'd200, 10'd202, 10'd211, 10'd196);
    // Second check fails on Y.
    send_window(10'd50, 10'd50, 10'd50, 10'd50,
                10'd50, 10'd50, 10'd50, 10'd61);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_ni <= 1'b1;
    directed();
    run_traffic(280);
    // Limit sweep, including both extremes; each write waits for idle.
    write_limit(10'd0);
    run_traffic(280);
    write_limit(10'h3ff);
    run_traffic(280);
    write_limit(sample_t'($urandom_range(1, 40)));
    run_traffic(280);
    write_limit(10'd1);
    run_traffic(280);
    write_limit(sample_t'($urandom));
    run_traffic(280);
    drain();
    repeat (8) @(posedge clk);
    if (checker_h.fails == 0 && checker_h.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (checker_h.pending() != 0)
        $error("%0d reports never arrived", checker_h.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
